>>> design/dscf_pkg.sv
// ----------------------------------------------------------------------------
// dscf_pkg
// Shared types and constants for the damped stereo comb filter.
// ----------------------------------------------------------------------------
package dscf_pkg;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
    localparam logic [1:0] REG_DAMP_COEFF    = 2'd2;
    localparam logic [1:0] REG_MIX_LEVEL     = 2'd3;

    localparam logic [12:0] DELAY_RST = 13'd100;
    localparam logic [15:0] FB_RST    = 16'd32768;
    localparam logic [15:0] DAMP_RST  = 16'd65470;
    localparam logic [16:0] MIX_RST   = 17'd32768;

    // Clamp limits
    localparam logic [15:0] FB_MAX   = 16'd64880;
    localparam logic [15:0] DAMP_MAX = 16'd65470;
    localparam logic [16:0] MIX_FULL = 17'd65536;

    typedef struct packed {
        logic [12:0] delay_length;
        logic [15:0] feedback_gain;
        logic [15:0] damp_coeff;
        logic [16:0] mix_level;
    } cfg_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;    // latch inputs, read delay taps
        logic clr_wr;    // write zero during the clearing sweep
        logic mul_damp;  // c * (tap - damp)
        logic mul_fb;    // update damp, damp * g
        logic mul_mix;   // write wet back, (wet - in) * m
        logic fin_load;  // load output register
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DAMP,
        ST_FB,
        ST_MIX,
        ST_FIN
    } state_t;

endpackage

>>> design/dscf_regs.sv
// ----------------------------------------------------------------------------
// dscf_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module dscf_regs
    import dscf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_DELAY_LENGTH:  cfg_next.delay_length  = pwdata[12:0];
                REG_FEEDBACK_GAIN: cfg_next.feedback_gain = pwdata[15:0];
                REG_DAMP_COEFF:    cfg_next.damp_coeff    = pwdata[15:0];
                REG_MIX_LEVEL:     cfg_next.mix_level     = pwdata[16:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_length  <= DELAY_RST;
            cfg_reg.feedback_gain <= FB_RST;
            cfg_reg.damp_coeff    <= DAMP_RST;
            cfg_reg.mix_level     <= MIX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_DELAY_LENGTH:  prdata = DATA_W'(cfg_reg.delay_length);
            REG_FEEDBACK_GAIN: prdata = DATA_W'(cfg_reg.feedback_gain);
            REG_DAMP_COEFF:    prdata = DATA_W'(cfg_reg.damp_coeff);
            REG_MIX_LEVEL:     prdata = DATA_W'(cfg_reg.mix_level);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> design/dscf_lane.sv
// ----------------------------------------------------------------------------
// dscf_lane
// One channel: delay line memory, damping state and a shared multiplier.
// ----------------------------------------------------------------------------
module dscf_lane
    import dscf_pkg::*;
#(
    parameter int DELAY_DEPTH = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cmd_t                          cmd,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [$clog2(DELAY_DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DELAY_DEPTH)-1:0] wr_addr,
    input  logic [15:0]                   gain,
    input  logic [15:0]                   coeff,
    input  logic [16:0]                   mix,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int S  = SAMPLE_BITS;
    localparam int PW = S + 19;
    localparam logic signed [S+3:0] HI = (S+4)'((64'sd1 <<< (S-1)) - 64'sd1);
    localparam logic signed [S+3:0] LO = -HI - (S+4)'(1);

    logic signed [S-1:0]  mem [DELAY_DEPTH];
    logic signed [S-1:0]  tap_reg;
    logic signed [S-1:0]  in_reg;
    logic signed [S-1:0]  damp_reg, damp_next;
    logic signed [PW-1:0] prod_reg, prod_full, prod_bias;
    logic signed [S:0]    mul_a;
    logic signed [17:0]   mul_b;
    logic signed [S+2:0]  prod_rnd;
    logic signed [S+3:0]  damp_sum, wet_sum;
    logic signed [S-1:0]  wet;
    logic signed [S+19:0] mix_sum;
    logic                 mem_we;
    logic signed [S-1:0]  mem_wdata;

    function automatic logic signed [S-1:0] sat_s(input logic signed [S+3:0] v);
        logic signed [S-1:0] r;
        if (v > HI) begin
            r = HI[S-1:0];
        end else if (v < LO) begin
            r = LO[S-1:0];
        end else begin
            r = v[S-1:0];
        end
        return r;
    endfunction

    // round half up: (p + 2^15) >> 16
    assign prod_bias = prod_reg + PW'(32768);
    assign prod_rnd  = prod_bias[PW-1:16];

    assign damp_sum  = (S+4)'(damp_reg) + (S+4)'(prod_rnd);
    assign damp_next = sat_s(damp_sum);
    assign wet_sum   = (S+4)'(in_reg) + (S+4)'(prod_rnd);
    assign wet       = sat_s(wet_sum);

    // in*(1-m) + wet*m == in*2^16 + (wet-in)*m
    assign mix_sum    = ((S+20)'(in_reg) <<< 16) + (S+20)'(prod_reg) + (S+20)'(32768);
    assign out_sample = sat_s(mix_sum[S+19:16]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_damp) begin
            mul_a = (S+1)'(tap_reg) - (S+1)'(damp_reg);
            mul_b = $signed({2'b00, coeff});
        end else if (cmd.mul_fb) begin
            mul_a = (S+1)'(damp_next);
            mul_b = $signed({2'b00, gain});
        end else if (cmd.mul_mix) begin
            mul_a = (S+1)'(wet) - (S+1)'(in_reg);
            mul_b = $signed({1'b0, mix});
        end
    end

    assign prod_full = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (cmd.mul_damp | cmd.mul_fb | cmd.mul_mix) begin
            prod_reg <= prod_full;
        end
        if (cmd.accept) begin
            in_reg <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg <= '0;
        end else if (cmd.mul_fb) begin
            damp_reg <= damp_next;
        end
    end

    // delay line: one write port, one registered read port
    assign mem_we    = cmd.clr_wr | cmd.mul_mix;
    assign mem_wdata = cmd.clr_wr ? '0 : wet;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= mem_wdata;
        end
        if (cmd.accept) begin
            tap_reg <= mem[rd_addr];
        end
    end

endmodule

>>> design/dscf_ctrl.sv
// ----------------------------------------------------------------------------
// dscf_ctrl
// Sequencer: clearing sweep, then four steps per stereo pair.
// ----------------------------------------------------------------------------
module dscf_ctrl
    import dscf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DAMP;
            end
            ST_DAMP: state_next = ST_FB;
            ST_FB:   state_next = ST_MIX;
            ST_MIX:  state_next = ST_FIN;
            ST_FIN: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.accept   = s_tready & s_tvalid;
        cmd.clr_wr   = (state_reg == ST_CLEAR);
        cmd.mul_damp = (state_reg == ST_DAMP);
        cmd.mul_fb   = (state_reg == ST_FB);
        cmd.mul_mix  = (state_reg == ST_MIX);
        cmd.fin_load = (state_reg == ST_FIN) & sts.out_free;
    end

endmodule

>>> design/dscf_datapath.sv
// ----------------------------------------------------------------------------
// dscf_datapath
// Pointers, config clamping, two channel lanes and the output register.
// ----------------------------------------------------------------------------
module dscf_datapath
    import dscf_pkg::*;
#(
    parameter int DELAY_DEPTH = 8192,
    parameter int SAMPLE_BITS = 24,
    parameter int TW          = 48
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  cmd_t          cmd,
    output sts_t          sts,
    input  logic [TW-1:0] s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [TW-1:0] m_tdata
);

    localparam int S  = SAMPLE_BITS;
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DELAY_DEPTH - 1);

    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [12:0]    dl_nz;
    logic [AW-1:0]  d_eff;
    logic [AW:0]    rd_diff;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [15:0]    gain, coeff;
    logic [16:0]    mix;
    logic signed [S-1:0] left_res, right_res;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [2*S-1:0] out_data_reg;

    // clamped settings
    assign gain  = (cfg.feedback_gain > FB_MAX) ? FB_MAX : cfg.feedback_gain;
    assign coeff = (cfg.damp_coeff > DAMP_MAX) ? DAMP_MAX : cfg.damp_coeff;
    assign mix   = (cfg.mix_level > MIX_FULL) ? MIX_FULL : cfg.mix_level;
    assign dl_nz = (cfg.delay_length == '0) ? 13'd1 : cfg.delay_length;

    always_comb begin
        if (32'(dl_nz) >= 32'(DELAY_DEPTH)) begin
            d_eff = LAST;
        end else begin
            d_eff = AW'(dl_nz);
        end
    end

    // tap address, wrapped at the ring depth
    assign rd_diff = {1'b0, wp_reg} - {1'b0, d_eff};
    assign rd_addr = rd_diff[AW] ? AW'(rd_diff + (AW+1)'(DELAY_DEPTH)) : rd_diff[AW-1:0];
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : wp_reg;

    always_comb begin
        wp_next = wp_reg;
        if (cmd.mul_mix) begin
            wp_next = (wp_reg == LAST) ? '0 : wp_reg + AW'(1);
        end
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr_wr) begin
            clr_cnt_next = (clr_cnt_reg == LAST) ? '0 : clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            wp_reg      <= wp_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    dscf_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_sample  ($signed(s_tdata[S-1:0])),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .gain       (gain),
        .coeff      (coeff),
        .mix        (mix),
        .out_sample (left_res)
    );

    dscf_lane #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_sample  ($signed(s_tdata[2*S-1:S])),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .gain       (gain),
        .coeff      (coeff),
        .mix        (mix),
        .out_sample (right_res)
    );

    // output register
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.clr_last = (clr_cnt_reg == LAST);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.fin_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_load) begin
            out_data_reg <= {right_res, left_res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TW'(out_data_reg);

    a_tap_not_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |-> rd_addr != wp_reg)
        else $error("tap address equals write pointer");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while held");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_no_clear_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !(cmd.accept || cmd.mul_mix || m_tvalid_reg))
        else $error("clearing sweep overlaps sample processing");

endmodule

>>> design/damped_stereo_comb_filter_core.sv
// ----------------------------------------------------------------------------
// damped_stereo_comb_filter_core
// Stereo lowpass-feedback comb filter with dry/wet mix.
// ----------------------------------------------------------------------------
// Each request on the s_ side carries one stereo pair (Q1.23 by default) and
// produces one blended pair on the m_ side. Per channel the delay ring is
// tapped delay_length samples behind the write pointer, the tap runs through
// a one-pole lowpass (damp_coeff), is scaled by feedback_gain, added to the
// input and written back; the output blends dry and wet by mix_level. Wet and
// output values saturate to the sample width. After reset the block sweeps
// both delay rings (DELAY_DEPTH entries, 8192 by default) to zero, one
// entry per cycle, s_tready low meanwhile; APB writes are taken throughout.
// The tap is read at the accepting edge; the result then reaches the output
// register after three passes through each lane's single multiplier
// (damping, feedback, mix) and the final round-and-saturate. The single
// multiplier and memory write port per lane mean a pair holds the core
// until its result is loaded; no new request is taken before then.
// A finished result waiting in the output register does not stop the next
// pair being accepted; only its final load waits for m_tready.
// Out-of-range settings are clamped: delay 0 acts as 1, gains at their
// limits, mix at fully wet. Registers lie at byte addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
module damped_stereo_comb_filter_core
    import dscf_pkg::*;
#(
    parameter int DELAY_DEPTH = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // APB configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [ADDR_W-1:0]                       paddr,
    input  logic [DATA_W-1:0]                       pwdata,
    output logic [DATA_W-1:0]                       prdata,
    output logic                                    pready,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,  // left_in, right_in
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata   // left_out, right_out
);

    localparam int TW = ((2*SAMPLE_BITS+7)/8)*8;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // register file
    dscf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    dscf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, delay rings and output register
    dscf_datapath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TW          (TW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> bench/comb_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_pair_checker
// Watches the APB and stream ports of the comb filter, predicts every blended
// pair and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module comb_pair_checker
    import dscf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [47:0]          s_tdata,   // left_in [23:0], right_in [47:24]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [47:0]          m_tdata,   // left_out [23:0], right_out [47:24]
    output int                   mismatch_count,
    output int                   pending_count
);

    localparam int     RING_DEPTH = 8192;
    localparam longint SAMPLE_MAX = 8388607;
    localparam longint SAMPLE_MIN = -8388608;

    cfg_t                 shadow_cfg;
    logic signed [23:0]   delay_ring [2][RING_DEPTH];
    longint               damp_state [2];
    int unsigned          wr_ptr;
    logic [47:0]          expected_pairs [$];
    int                   mismatches;
    int                   results_seen;

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    // round half up, floor shift
    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint comb_lane(input int ch, input longint dry,
                                         input int unsigned rd, input longint g,
                                         input longint c, input longint m);
        longint tap;
        longint wet;
        tap = delay_ring[ch][rd];
        damp_state[ch] = clamp_sample(damp_state[ch]
                                      + round_q16(c * (tap - damp_state[ch])));
        wet = clamp_sample(dry + round_q16(damp_state[ch] * g));
        delay_ring[ch][wr_ptr] = wet[23:0];
        return clamp_sample(round_q16(dry * (65536 - m) + wet * m));
    endfunction

    task automatic comb_step(input logic [47:0] req, output logic [47:0] res);
        longint d;
        longint g;
        longint c;
        longint m;
        longint left_o;
        longint right_o;
        int unsigned rd;
        d = shadow_cfg.delay_length;
        g = shadow_cfg.feedback_gain;
        c = shadow_cfg.damp_coeff;
        m = shadow_cfg.mix_level;
        if (d < 1) d = 1;
        if (d >= RING_DEPTH) d = RING_DEPTH - 1;
        if (g > FB_MAX) g = FB_MAX;
        if (c > DAMP_MAX) c = DAMP_MAX;
        if (m > MIX_FULL) m = MIX_FULL;
        rd = (wr_ptr + RING_DEPTH - d) % RING_DEPTH;
        left_o  = comb_lane(0, longint'($signed(req[23:0])), rd, g, c, m);
        right_o = comb_lane(1, longint'($signed(req[47:24])), rd, g, c, m);
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        res = {right_o[23:0], left_o[23:0]};
    endtask

    task automatic clear_model();
        for (int i = 0; i < RING_DEPTH; i++) begin
            delay_ring[0][i] = '0;
            delay_ring[1][i] = '0;
        end
        damp_state[0] = 0;
        damp_state[1] = 0;
        wr_ptr = 0;
        shadow_cfg.delay_length  = DELAY_RST;
        shadow_cfg.feedback_gain = FB_RST;
        shadow_cfg.damp_coeff    = DAMP_RST;
        shadow_cfg.mix_level     = MIX_RST;
        expected_pairs.delete();
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] comb check: %s", $time, msg);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        results_seen = 0;
        mismatch_count = 0;
        pending_count = 0;
        clear_model();
    end

    always @(posedge aclk) begin
        logic [47:0] want;
        logic [47:0] predicted;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_DELAY_LENGTH:  shadow_cfg.delay_length  = pwdata[12:0];
                    REG_FEEDBACK_GAIN: shadow_cfg.feedback_gain = pwdata[15:0];
                    REG_DAMP_COEFF:    shadow_cfg.damp_coeff    = pwdata[15:0];
                    REG_MIX_LEVEL:     shadow_cfg.mix_level     = pwdata[16:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_tdata[23:0] !== want[23:0])
                        report_mismatch($sformatf("result %0d left_out %h, want %h",
                                        results_seen, m_tdata[23:0], want[23:0]));
                    if (m_tdata[47:24] !== want[47:24])
                        report_mismatch($sformatf("result %0d right_out %h, want %h",
                                        results_seen, m_tdata[47:24], want[47:24]));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready) begin
                comb_step(s_tdata, predicted);
                expected_pairs.push_back(predicted);
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= expected_pairs.size();
    end

endmodule

>>> bench/damped_stereo_comb_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_stereo_comb_filter_core_tb
// Drives stereo pairs and register settings into the comb filter core.
// ----------------------------------------------------------------------------
// Stimulus only: a directed opening (sample extremes, every clamp on the
// registers, zero delay, dry and fully wet mix), then randomised phases each
// with fresh settings. Both stream sides idle at random; the checker beside
// the core predicts and compares, and hands back its mismatch count.
// ----------------------------------------------------------------------------
module damped_stereo_comb_filter_core_tb;
    import dscf_pkg::*;

    localparam int GAP_MAX       = 12;
    localparam int RANDOM_PHASES = 11;
    // covers the clear sweep and ~1100 requests with worst-case gaps, many times over
    localparam int CYCLE_LIMIT   = 400000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;   // left_in [23:0], right_in [47:24]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;        // left_out [23:0], right_out [47:24]

    int                   mismatch_count;
    int                   pending_count;
    int                   cycle_count = 0;
    bit                   send_steady = 1'b0;   // stretch with no sender gaps
    bit                   recv_steady = 1'b0;   // stretch with no receiver stalls

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hang anywhere ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    damped_stereo_comb_filter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    comb_pair_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Result side: random stall before each result, with steady stretches.
    // m_tready is only lowered when a stall is drawn, so it never gets two
    // assignments in one step.
    initial begin
        int stall;
        forever begin
            if ($urandom_range(0, 29) == 0) recv_steady = !recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Setup cycle, then access cycle; written at the edge where pready is seen
    task automatic apb_write(input logic [1:0] reg_idx, input logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One stereo request; tvalid stays high across back-to-back requests
    task automatic send_pair(input logic [23:0] left_s, input logic [23:0] right_s);
        int gap;
        if ($urandom_range(0, 29) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {right_s, left_s};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off until every predicted pair has come back. The first edge lets
    // the count pick up a request accepted at this very edge.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'($urandom_range(0, 255));
            3:       return -24'($urandom_range(1, 256));
            default: return 24'($urandom());
        endcase
    endfunction

    // Mostly short delays so feedback builds up within a phase; clamps now and then
    task automatic random_settings();
        logic [DATA_W-1:0] delay_v;
        logic [DATA_W-1:0] fb_v;
        logic [DATA_W-1:0] damp_v;
        logic [DATA_W-1:0] mix_v;
        case ($urandom_range(0, 9))
            0:       delay_v = 0;
            1:       delay_v = 8191;
            2, 3, 4: delay_v = $urandom_range(1, 8);
            5:       delay_v = $urandom_range(1, 8191);
            default: delay_v = $urandom_range(1, 400);
        endcase
        case ($urandom_range(0, 7))
            0:       fb_v = $urandom_range(64881, 65535);
            1:       fb_v = 0;
            default: fb_v = $urandom_range(0, 64880);
        endcase
        case ($urandom_range(0, 7))
            0:       damp_v = $urandom_range(65471, 65535);
            1:       damp_v = 0;
            default: damp_v = $urandom_range(0, 65470);
        endcase
        case ($urandom_range(0, 7))
            0:       mix_v = $urandom_range(65537, 131071);
            1:       mix_v = 0;
            2:       mix_v = 65536;
            default: mix_v = $urandom_range(0, 65536);
        endcase
        apb_write(REG_DELAY_LENGTH, delay_v);
        apb_write(REG_FEEDBACK_GAIN, fb_v);
        apb_write(REG_DAMP_COEFF, damp_v);
        apb_write(REG_MIX_LEVEL, mix_v);
    endtask

    initial begin
        int phase_len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings; the first requests wait out the clearing sweep
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hAAAAAA, 24'h555555);
        send_pair(24'h555555, 24'hAAAAAA);
        send_pair(24'hFFFFFF, 24'h000001);
        drain_results();

        // Shortest delay, feedback and damping above their limits, fully wet:
        // repeated full scale drives the wet sum into saturation
        apb_write(REG_DELAY_LENGTH, 1);
        apb_write(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
        apb_write(REG_DAMP_COEFF, 32'h0000_FFFF);
        apb_write(REG_MIX_LEVEL, 65536);
        repeat (5) send_pair(24'h7FFFFF, 24'h7FFFFF);
        repeat (2) send_pair(24'h800000, 24'h800000);
        drain_results();

        // Zero delay (acts as one), no feedback, no damping, fully dry
        apb_write(REG_DELAY_LENGTH, 0);
        apb_write(REG_FEEDBACK_GAIN, 0);
        apb_write(REG_DAMP_COEFF, 0);
        apb_write(REG_MIX_LEVEL, 0);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h123456, 24'hFEDCBA);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'h000001, 24'hFFFFFF);
        drain_results();

        // Longest delay, gains exactly at their limits, mix above fully wet
        apb_write(REG_DELAY_LENGTH, 8191);
        apb_write(REG_FEEDBACK_GAIN, 64880);
        apb_write(REG_DAMP_COEFF, 65470);
        apb_write(REG_MIX_LEVEL, 32'h0001_FFFF);
        repeat (5) send_pair(random_sample(), random_sample());
        drain_results();

        // Random phases, settings changed only once the core has gone quiet
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings();
            phase_len = $urandom_range(60, 140);
            repeat (phase_len) send_pair(random_sample(), random_sample());
            drain_results();
        end

        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/dscf_pkg.sv
design/dscf_regs.sv
design/dscf_lane.sv
design/dscf_ctrl.sv
design/dscf_datapath.sv
design/damped_stereo_comb_filter_core.sv
bench/comb_pair_checker.sv
bench/damped_stereo_comb_filter_core_tb.sv
